[hdl/teq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types, codes and sizes for the triple-ended queue cell chain.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int DATA_W     = 32;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SZ   = 32;
  localparam int N_GROUPS   = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_POP_LEFT    = 3'd0,
    MODE_POP_MIDDLE  = 3'd1,
    MODE_POP_RIGHT   = 3'd2,
    MODE_PUSH_LEFT   = 3'd3,
    MODE_PUSH_MIDDLE = 3'd4,
    MODE_PUSH_RIGHT  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_POP_OK    = 2'd0,
    STS_PUSH_OK   = 2'd1,
    STS_POP_EMPTY = 2'd2,
    STS_PUSH_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_REDUCE
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] pos;
    value_t           value;
  } cell_cmd_t;

  // Stored values are sign-extended (or cut) to the output width.
  function automatic logic [DATA_W-1:0] to_out(value_t v);
    logic signed [VALUE_BITS-1:0] s;
    s = v;
    return DATA_W'(s);
  endfunction

endpackage

[hdl/teq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_cell
// One queue position: holds a value and shifts it with its neighbors when an
// element is inserted or removed at or below its own position.
// ----------------------------------------------------------------------------
module teq_cell
  import teq_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  cell_cmd_t        cmd_i,
  input  value_t           prev_i,
  input  value_t           next_i,
  output value_t           value_o,
  output value_t           leaf_o
);

  value_t value_q;
  value_t value_d;
  logic   at_pos;
  logic   above_pos;

  assign at_pos    = (cell_idx_i == cmd_i.pos);
  assign above_pos = (cell_idx_i > cmd_i.pos);

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (at_pos) begin
          value_d = cmd_i.value;
        end else if (above_pos) begin
          value_d = prev_i;
        end
      end
      OP_REMOVE: begin
        if (at_pos || above_pos) begin
          value_d = next_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Only the addressed cell feeds the read tree.
  assign leaf_o  = at_pos ? value_q : '0;

endmodule

[hdl/teq_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_reduce
// Registered OR tree that collects the value of the one addressed cell.
// ----------------------------------------------------------------------------
module teq_reduce
  import teq_pkg::*;
(
  input  logic   clk_i,
  input  logic   load_i,
  input  value_t leaf_i [CAPACITY],
  output value_t result_o
);

  value_t group_d [N_GROUPS];
  value_t group_q [N_GROUPS];

  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      group_d[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (g * GROUP_SZ + k < CAPACITY) begin
          group_d[g] = group_d[g] | leaf_i[g * GROUP_SZ + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      group_q <= group_d;
    end
  end

  always_comb begin
    result_o = '0;
    for (int g = 0; g < N_GROUPS; g++) begin
      result_o = result_o | group_q[g];
    end
  end

endmodule

[hdl/triple_ended_queue.sv]
`timescale 1ns / 1ps
// A command is accepted in the idle state; in the shift state the cell chain
// shifts while the first level of the read tree registers the addressed value,
// and the reduce state loads the result into the output register. A new command
// is accepted only after the previous one has passed the shift and reduce
// states; a result left waiting in the output register holds the next command off.
// Reset clears the element count, the control state and the output valid;
// the cell contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
// triple_ended_queue
// Queue with push and pop at the left end, the middle and the right end,
// held in order in a chain of cells; the middle is position count / 2.
// ----------------------------------------------------------------------------
module triple_ended_queue
  import teq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] push_value
  input  logic [MODE_W-1:0]   s_axis_tuser,   // [2:0] mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] popped_value
  output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cell_cmd_t        cmd_q, cmd_d;
  status_e          status_q, status_d;
  logic             out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  status_e          out_status_q, out_status_d;

  logic             in_fire;
  logic             out_free;
  logic             out_load;
  logic             reduce_load;
  cell_cmd_t        cell_cmd;
  mode_e            mode;
  logic             is_pop;
  logic             is_empty;
  logic             is_full;
  logic [CNT_W:0]   cnt_inc;
  logic [IDX_W-1:0] pos;
  value_t           cell_val [CAPACITY];
  value_t           leaf_val [CAPACITY];
  value_t           read_val;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // ---- command decode ----
  assign mode     = mode_e'(s_axis_tuser);
  assign is_pop   = (mode == MODE_POP_LEFT) || (mode == MODE_POP_MIDDLE) ||
                    (mode == MODE_POP_RIGHT);
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == CNT_W'(CAPACITY));
  assign cnt_inc  = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    case (mode)
      MODE_POP_LEFT:    pos = '0;
      MODE_POP_MIDDLE:  pos = IDX_W'(cnt_q >> 1);
      MODE_POP_RIGHT:   pos = IDX_W'(cnt_q - 1'b1);
      MODE_PUSH_LEFT:   pos = '0;
      // Insert behind the old middle when the count is odd.
      MODE_PUSH_MIDDLE: pos = IDX_W'(cnt_inc >> 1);
      default:          pos = IDX_W'(cnt_q);
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    if (in_fire) begin
      cmd_d.pos   = pos;
      cmd_d.value = VALUE_BITS'(s_axis_tdata);
      if (is_pop) begin
        if (is_empty) begin
          cmd_d.op = OP_NONE;
          status_d = STS_POP_EMPTY;
        end else begin
          cmd_d.op = OP_REMOVE;
          status_d = STS_POP_OK;
          cnt_d    = cnt_q - 1'b1;
        end
      end else begin
        if (is_full) begin
          cmd_d.op = OP_NONE;
          status_d = STS_PUSH_FULL;
        end else begin
          cmd_d.op = OP_INSERT;
          status_d = STS_PUSH_OK;
          cnt_d    = cnt_q + 1'b1;
        end
      end
    end
  end

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_d = S_REDUCE;
      end
      S_REDUCE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---- state outputs ----
  always_comb begin
    s_axis_tready = 1'b0;
    reduce_load   = 1'b0;
    out_load      = 1'b0;
    cell_cmd      = cmd_q;
    cell_cmd.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      S_SHIFT: begin
        // The chain shifts and the tree samples the old contents together.
        reduce_load = 1'b1;
        cell_cmd    = cmd_q;
      end
      S_REDUCE: begin
        out_load = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // ---- output register ----
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = status_q;
      out_data_d   = (status_q == STS_POP_OK) ? to_out(read_val) : '0;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    status_q     <= status_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t prev_v;
    value_t next_v;

    if (i == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_prev
      assign prev_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_next
      assign next_v = cell_val[i+1];
    end

    teq_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .cmd_i      (cell_cmd),
      .prev_i     (prev_v),
      .next_i     (next_v),
      .value_o    (cell_val[i]),
      .leaf_o     (leaf_val[i])
    );
  end

  teq_reduce u_reduce (
    .clk_i    (clk_i),
    .load_i   (reduce_load),
    .leaf_i   (leaf_val),
    .result_o (read_val)
  );

  // ---- assertions ----
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_shift_then_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |=> state_q == S_REDUCE)
    else $error("shift cycle not followed by reduce cycle");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_pop && is_full) |=> (status_q == STS_PUSH_FULL && cnt_q == $past(cnt_q)))
    else $error("push on full queue not flagged");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_REDUCE))
    else $error("result appeared outside the reduce cycle");

endmodule

[dv/teq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_checker
// Watches both stream channels of the triple-ended queue. It keeps its own
// ordered copy of the queue contents, works out the popped value and status
// for every accepted command, and compares each accepted result against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module teq_checker
  import teq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] push_value
  input  logic [MODE_W-1:0]   s_axis_tuser,   // [2:0] mode
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] popped_value
  input  logic [STATUS_W-1:0] m_axis_tuser,   // [1:0] status
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    status_e           status;
  } queue_result_t;

  // Queue contents from the left end to the right end.
  value_t        contents[$];
  queue_result_t results_due[$];
  int            fail_count    = 0;
  int            pending_count = 0;

  assign mismatches_o = fail_count;
  assign pending_o    = pending_count;

  // The two halves always stay balanced, so the middle is the element at
  // index size / 2, and a middle push lands at index (size + 1) / 2.
  function automatic queue_result_t apply_command(logic [MODE_W-1:0] mode, value_t value);
    queue_result_t res;
    int            n;
    n          = contents.size();
    res.popped = '0;
    if (mode <= MODE_POP_RIGHT) begin
      if (n == 0) begin
        res.status = STS_POP_EMPTY;
      end else begin
        value_t v;
        res.status = STS_POP_OK;
        case (mode)
          MODE_POP_LEFT: begin
            v = contents[0];
            contents.delete(0);
          end
          MODE_POP_MIDDLE: begin
            v = contents[n / 2];
            contents.delete(n / 2);
          end
          default: begin
            v = contents[n - 1];
            contents.delete(n - 1);
          end
        endcase
        res.popped = DATA_W'($signed(v));
      end
    end else if (n >= CAPACITY) begin
      res.status = STS_PUSH_FULL;
    end else begin
      res.status = STS_PUSH_OK;
      case (mode)
        MODE_PUSH_LEFT: begin
          contents.push_front(value);
        end
        MODE_PUSH_MIDDLE: begin
          contents.insert((n + 1) / 2, value);
        end
        // The two unused mode codes behave as a right push.
        default: begin
          contents.push_back(value);
        end
      endcase
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      contents.delete();
      results_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(apply_command(s_axis_tuser, s_axis_tdata[VALUE_BITS-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          note_mismatch("unrequested result", '0, m_axis_tdata);
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (m_axis_tdata !== want.popped) begin
            note_mismatch("popped value", want.popped, m_axis_tdata);
          end
          if (m_axis_tuser !== want.status) begin
            note_mismatch("status", DATA_W'(want.status), DATA_W'(m_axis_tuser));
          end
        end
      end
    end
    pending_count = results_due.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the triple-ended queue with a short directed sequence and then with
// random command phases that walk the queue around empty, fill it to its
// capacity and then pop mostly from the full queue. Both channels idle at random, and the result
// side holds off once for a long stretch to back up the command side.
// ----------------------------------------------------------------------------
module testbench;
  import teq_pkg::*;

  localparam int                LIMIT         = 200000;
  localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata;   // [31:0] push_value
  logic [MODE_W-1:0]   s_axis_tuser;   // [2:0] mode
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DATA_W-1:0]   m_axis_tdata;   // [31:0] popped_value
  logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status

  int mismatches;
  int pending;
  int cycle_count  = 0;
  int results_seen = 0;
  int sent_count   = 0;
  int occupancy    = 0;
  int empty_pops   = 0;
  int full_pushes  = 0;

  triple_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  teq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
    end
    if (cycle_count == LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, one clean stretch, and one long hold-off
  // that leaves a result waiting in the block so that it refuses commands.
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 300) begin
        held          = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if (results_seen >= 800 && results_seen < 1100) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 11);
      end
    end
  end

  // One command transfer; the occupancy count only shapes the stimulus.
  task automatic issue_command(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    while (!(sent_count >= 700 && sent_count < 1000) && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
    if (mode <= MODE_POP_RIGHT) begin
      if (occupancy == 0) empty_pops++;
      else occupancy--;
    end else begin
      if (occupancy == CAPACITY) full_pushes++;
      else occupancy++;
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(int push_pct);
    if ($urandom_range(99) < push_pct) begin
      case ($urandom_range(19))
        0:       return MODE_UNUSED_A;
        1:       return MODE_UNUSED_B;
        2, 3, 4, 5, 6, 7:
                 return MODE_PUSH_LEFT;
        8, 9, 10, 11, 12, 13:
                 return MODE_PUSH_MIDDLE;
        default: return MODE_PUSH_RIGHT;
      endcase
    end
    case ($urandom_range(2))
      0:       return MODE_POP_LEFT;
      1:       return MODE_POP_MIDDLE;
      default: return MODE_POP_RIGHT;
    endcase
  endfunction

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_POP_LEFT;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pops on an empty queue.
    issue_command(MODE_POP_LEFT, 32'hFFFF_FFFF);
    issue_command(MODE_POP_MIDDLE, '0);
    issue_command(MODE_POP_RIGHT, 32'h8000_0000);
    // A single element lives in the right half, so a left pop takes it there.
    issue_command(MODE_PUSH_RIGHT, 32'h7FFF_FFFF);
    issue_command(MODE_POP_LEFT, '0);
    // Build six elements; the second middle push meets a longer right half.
    issue_command(MODE_PUSH_LEFT, 32'h8000_0000);
    issue_command(MODE_PUSH_MIDDLE, 32'hFFFF_FFFF);
    issue_command(MODE_PUSH_RIGHT, '0);
    issue_command(MODE_PUSH_MIDDLE, 32'h5555_5555);
    issue_command(MODE_UNUSED_A, 32'hAAAA_AAAA);
    issue_command(MODE_UNUSED_B, 32'h0000_0001);
    issue_command(MODE_POP_MIDDLE, '0);
    issue_command(MODE_POP_RIGHT, '0);
    issue_command(MODE_POP_LEFT, '0);
    issue_command(MODE_POP_MIDDLE, '0);
    issue_command(MODE_POP_MIDDLE, '0);
    issue_command(MODE_POP_RIGHT, '0);
    issue_command(MODE_POP_MIDDLE, '0);

    // Random walk close to empty.
    repeat (200) issue_command(pick_mode(50), pick_value());
    // Push-heavy until the queue is full, then pushes against a full queue.
    while (occupancy < CAPACITY) issue_command(pick_mode(92), pick_value());
    repeat (12) issue_command(pick_mode(100), pick_value());
    // Mostly pops from the full queue.
    repeat (100) issue_command(pick_mode(30), pick_value());

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d results; queue reached %0d entries.",
             sent_count, results_seen, CAPACITY);
    $display("Pops on an empty queue: %0d, pushes refused on a full queue: %0d.",
             empty_pops, full_pushes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
